@@ rtl/lmcw_pkg.sv @@
package lmcw_pkg;

  // Fixed geometry of one display driver
  localparam int unsigned ROWS_PER_DEVICE = 8;
  localparam int unsigned ROW_W           = 3;

  // Action codes
  localparam logic [1:0] ACT_LED    = 2'd0;
  localparam logic [1:0] ACT_ROW    = 2'd1;
  localparam logic [1:0] ACT_COLUMN = 2'd2;
  localparam logic [1:0] ACT_RAW    = 2'd3;

  // Word and mask constants
  localparam logic [15:0]      NOP_WORD = 16'h0000;
  localparam logic [7:0]       LED_MASK = 8'b1000_0000;
  localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] device;
    logic [2:0] row;
    logic [2:0] column;
    logic       led_on;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] serial_word;
    logic        frame_end;
    logic        item_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_WRITE,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic modify;
    logic write_row;
    logic emit;
    logic next_row;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       in_range;
    logic [1:0] new_action;
    logic [1:0] action;
    logic       last_word;
    logic       last_row;
    logic       slot_free;
  } sts_t;

endpackage

@@ rtl/led_matrix_chain_writer.sv @@
// Flow: a raw write goes straight to emitting, a row write first writes the buffer row, and
// a single LED first reads and modifies its buffer row; the first word is then registered, and
// one word per cycle follows while the output is not stalled, device_count words per frame.
// Column writes repeat read, modify and emit for each of the eight rows. A new item is taken
// only once the previous one is done; device_count is capped at MAX_DEVICES.
// Reset: synchronous, clears chain length to 1, marks every buffer row unwritten (reads 0).
module led_matrix_chain_writer #(
  parameter int unsigned MAX_DEVICES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  lmcw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lmcw_pkg::out_item_t out_data
);

  lmcw_pkg::cmd_t cmd;
  lmcw_pkg::sts_t sts;

  // Sequencer
  lmcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Buffer and word generation
  lmcw_dpath #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/lmcw_ctrl.sv @@
module lmcw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lmcw_pkg::sts_t  sts,
  output lmcw_pkg::cmd_t  cmd
);

  lmcw_pkg::state_t state;
  lmcw_pkg::state_t state_next;
  logic             accept;
  logic             more_rows;

  assign in_stall  = (state != lmcw_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign more_rows = (sts.action == lmcw_pkg::ACT_COLUMN) && !sts.last_row;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmcw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lmcw_pkg::ST_IDLE: begin
        if (accept && sts.in_range) begin
          case (sts.new_action)
            lmcw_pkg::ACT_ROW: state_next = lmcw_pkg::ST_WRITE;
            lmcw_pkg::ACT_RAW: state_next = lmcw_pkg::ST_EMIT;
            default:           state_next = lmcw_pkg::ST_READ;
          endcase
        end
      end
      lmcw_pkg::ST_READ:   state_next = lmcw_pkg::ST_MODIFY;
      lmcw_pkg::ST_MODIFY: state_next = lmcw_pkg::ST_EMIT;
      lmcw_pkg::ST_WRITE:  state_next = lmcw_pkg::ST_EMIT;
      lmcw_pkg::ST_EMIT: begin
        if (sts.slot_free && sts.last_word) begin
          state_next = more_rows ? lmcw_pkg::ST_READ : lmcw_pkg::ST_IDLE;
        end
      end
      default: state_next = lmcw_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.rd        = (state == lmcw_pkg::ST_READ);
    cmd.modify    = (state == lmcw_pkg::ST_MODIFY);
    cmd.write_row = (state == lmcw_pkg::ST_WRITE);
    cmd.emit      = (state == lmcw_pkg::ST_EMIT) && sts.slot_free;
    cmd.next_row  = cmd.emit && sts.last_word && more_rows;
  end

  // Emit only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.slot_free)
    else $error("word emitted into occupied output register");

  // Leave idle only on an accepted, in-range transfer
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == lmcw_pkg::ST_IDLE && !(accept && sts.in_range)) |=>
      (state == lmcw_pkg::ST_IDLE))
    else $error("left idle without an accepted item");

  // A frame read is always followed by its modify step
  a_read_modify: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> cmd.modify)
    else $error("buffer read not followed by modify");

endmodule

@@ rtl/lmcw_dpath.sv @@
module lmcw_dpath #(
  parameter int unsigned MAX_DEVICES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  lmcw_pkg::in_item_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output lmcw_pkg::out_item_t out_data,
  input  lmcw_pkg::cmd_t      cmd,
  output lmcw_pkg::sts_t      sts
);

  localparam int unsigned DEPTH  = MAX_DEVICES * lmcw_pkg::ROWS_PER_DEVICE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [3:0]  MAX_CNT = 4'(MAX_DEVICES);

  logic [3:0]                 dev_count;
  logic [3:0]                 eff_count;
  lmcw_pkg::in_item_t         item_q;
  logic [lmcw_pkg::ROW_W-1:0] row_q;
  logic [2:0]                 word_q;
  logic [7:0]                 data_q;
  logic [7:0]                 mem [DEPTH];
  logic [DEPTH-1:0]           vld;
  logic [7:0]                 rd_q;
  logic                       rd_vld_q;
  logic [ADDR_W-1:0]          addr;
  logic                       wr_en;
  logic [7:0]                 wr_data;
  logic                       led_bit;
  logic [7:0]                 mask;
  logic [7:0]                 old_byte;
  logic [7:0]                 new_byte;
  logic [3:0]                 lead;
  logic                       hit;
  logic [3:0]                 row_plus;
  logic                       slot_free;
  logic                       last_word;
  logic                       last_row;
  lmcw_pkg::out_item_t        word;

  // Chain length register
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_count <= 4'd1;
    end else if (cfg_we) begin
      dev_count <= cfg_wdata;
    end
  end

  assign eff_count = (dev_count > MAX_CNT) ? MAX_CNT : dev_count;

  // Latch item, track row and word position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= in_data;
      data_q <= in_data.value;
      row_q  <= (in_data.action == lmcw_pkg::ACT_COLUMN) ? '0 : in_data.row;
      word_q <= '0;
    end else begin
      if (cmd.modify) begin
        data_q <= new_byte;
      end
      if (cmd.next_row) begin
        row_q <= row_q + 1'b1;
      end
      if (cmd.emit) begin
        word_q <= last_word ? 3'd0 : word_q + 3'd1;
      end
    end
  end

  // Read-modify of one buffer row
  assign addr     = ADDR_W'({item_q.device, row_q});
  assign led_bit  = (item_q.action == lmcw_pkg::ACT_COLUMN) ?
                    item_q.value[3'(lmcw_pkg::LAST_ROW - row_q)] : item_q.led_on;
  assign mask     = lmcw_pkg::LED_MASK >> item_q.column;
  assign old_byte = rd_vld_q ? rd_q : 8'h00;
  assign new_byte = led_bit ? (old_byte | mask) : (old_byte & ~mask);
  assign wr_en    = cmd.modify || cmd.write_row;
  assign wr_data  = cmd.modify ? new_byte : item_q.value;

  // Shadow buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_q     <= mem[addr];
      rd_vld_q <= vld[addr];
    end
  end

  // Written marks: unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[addr] <= 1'b1;
    end
  end

  // Build the current frame word
  assign lead      = eff_count - 4'd1 - {1'b0, item_q.device};
  assign hit       = ({1'b0, word_q} == lead);
  assign row_plus  = {1'b0, row_q} + 4'd1;
  assign last_word = ({1'b0, word_q} == (eff_count - 4'd1));
  assign last_row  = (row_q == lmcw_pkg::LAST_ROW);

  always_comb begin
    word.serial_word = hit ? {4'b0000, row_plus, data_q} : lmcw_pkg::NOP_WORD;
    word.frame_end   = last_word;
    word.item_end    = last_word &&
                       ((item_q.action != lmcw_pkg::ACT_COLUMN) || last_row);
  end

  // Output register
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= word;
    end
  end

  // Status
  always_comb begin
    sts            = '0;
    sts.in_range   = ({1'b0, in_data.device} < eff_count);
    sts.new_action = in_data.action;
    sts.action     = item_q.action;
    sts.last_word  = last_word;
    sts.last_row   = last_row;
    sts.slot_free  = slot_free;
  end

  // Item end only on a frame end
  a_item_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.item_end) |-> out_data.frame_end)
    else $error("item end without frame end");

  // A written row is marked valid
  a_wr_mark: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> vld[$past(addr)])
    else $error("written buffer row not marked");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MAX_DEV       = 8;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 35;

  logic                clk;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [3:0]          cfg_wdata = 4'd0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lmcw_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lmcw_pkg::out_item_t out_data;

  // Shadow copy of the display image and chain setting
  logic [7:0]          shadow_rows [64];
  logic [3:0]          chain_setting;
  lmcw_pkg::out_item_t expected_words [$];
  lmcw_pkg::out_item_t oldest_word;

  // Run bookkeeping
  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned chains_used   = 0;
  int unsigned idle_cycles   = 0;

  // Sender and receiver pacing controls
  int unsigned burst_left      = 0;
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned hold_request    = 0;
  int unsigned hold_left       = 0;
  int unsigned run_left        = 0;
  bit          stall_now;

  led_matrix_chain_writer #(
    .MAX_DEVICES(MAX_DEV)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 64; i++) shadow_rows[i] = 8'h00;
    chain_setting = 4'd1;
  end

  // Number of drivers that actually take part in the chain
  function automatic int unsigned active_devices();
    return (chain_setting > MAX_DEV) ? MAX_DEV : chain_setting;
  endfunction

  function automatic lmcw_pkg::in_item_t make_item(logic [1:0] action, logic [2:0] device,
                                                   logic [2:0] row, logic [2:0] column,
                                                   logic led_on, logic [7:0] value);
    lmcw_pkg::in_item_t it;
    it.action = action;
    it.device = device;
    it.row    = row;
    it.column = column;
    it.led_on = led_on;
    it.value  = value;
    return it;
  endfunction

  function automatic lmcw_pkg::in_item_t random_item();
    lmcw_pkg::in_item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.row    = 3'($urandom_range(0, 7));
    it.column = 3'($urandom_range(0, 7));
    it.led_on = 1'($urandom_range(0, 1));
    it.value  = 8'($urandom_range(0, 255));
    // Mostly target a driver in the chain, otherwise any driver address, which may lie past its end
    if (active_devices() > 0 && $urandom_range(0, 99) < 85)
      it.device = 3'($urandom_range(0, active_devices() - 1));
    else
      it.device = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // Queue one frame: NOPs for the drivers past the target, data word, NOPs for the rest
  task automatic push_frame(input logic [2:0] dev, input logic [2:0] row,
                            input logic [7:0] data);
    int unsigned         n;
    int unsigned         lead;
    int unsigned         i;
    lmcw_pkg::out_item_t w;
    n    = active_devices();
    lead = n - 1 - dev;
    for (i = 0; i < n; i++) begin
      w.serial_word = (i == lead) ? {4'd0, {1'b0, row} + 4'd1, data} : lmcw_pkg::NOP_WORD;
      w.frame_end   = (i == n - 1);
      w.item_end    = 1'b0;
      expected_words.push_back(w);
    end
  endtask

  task automatic update_led(input logic [2:0] dev, input logic [2:0] row,
                            input logic [2:0] col, input logic on);
    logic [5:0] idx;
    logic [7:0] mask;
    idx  = {dev, row};
    mask = lmcw_pkg::LED_MASK >> col;
    if (on)
      shadow_rows[idx] = shadow_rows[idx] | mask;
    else
      shadow_rows[idx] = shadow_rows[idx] & ~mask;
    push_frame(dev, row, shadow_rows[idx]);
  endtask

  // Update the shadow image and queue the words one accepted item causes
  task automatic predict_words(input lmcw_pkg::in_item_t it);
    lmcw_pkg::out_item_t w;
    int                  r;
    if (it.device < active_devices()) begin
      case (it.action)
        lmcw_pkg::ACT_LED: begin
          update_led(it.device, it.row, it.column, it.led_on);
        end
        lmcw_pkg::ACT_ROW: begin
          shadow_rows[{it.device, it.row}] = it.value;
          push_frame(it.device, it.row, it.value);
        end
        lmcw_pkg::ACT_COLUMN: begin
          for (r = 0; r < 8; r++)
            update_led(it.device, r[2:0], it.column, it.value[7 - r]);
        end
        default: begin
          push_frame(it.device, it.row, it.value);
        end
      endcase
      w = expected_words.pop_back();
      w.item_end = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  // Offer one item in bursts, with random gaps between bursts when sender_gaps is set; hold it until the transfer
  task automatic send_item(input lmcw_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_words(it);
    items_sent++;
  endtask

  // Drop valid and wait until every expected word has arrived, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_chain(input logic [3:0] setting);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= setting;
    @(posedge clk);
    cfg_we    <= 1'b0;
    chain_setting = setting;
    chains_used++;
  endtask

  task automatic test_directed();
    write_chain(4'd8);
    // extremes of position, row and column, all four actions
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd0, 3'd0, 3'd0, 1'b1, 8'h00));
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd7, 3'd7, 3'd7, 1'b1, 8'hFF));
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd0, 3'd0, 3'd0, 1'b0, 8'hFF));
    send_item(make_item(lmcw_pkg::ACT_ROW,    3'd3, 3'd4, 3'd0, 1'b0, 8'hFF));
    send_item(make_item(lmcw_pkg::ACT_ROW,    3'd3, 3'd4, 3'd7, 1'b1, 8'h00));
    send_item(make_item(lmcw_pkg::ACT_COLUMN, 3'd7, 3'd0, 3'd0, 1'b0, 8'hFF));
    send_item(make_item(lmcw_pkg::ACT_COLUMN, 3'd0, 3'd5, 3'd7, 1'b1, 8'hA5));
    send_item(make_item(lmcw_pkg::ACT_COLUMN, 3'd7, 3'd2, 3'd0, 1'b1, 8'h00));
    // raw writes leave the image alone; the LED after them shows it
    send_item(make_item(lmcw_pkg::ACT_RAW,    3'd0, 3'd0, 3'd3, 1'b1, 8'hFF));
    send_item(make_item(lmcw_pkg::ACT_RAW,    3'd7, 3'd7, 3'd0, 1'b0, 8'h00));
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd0, 3'd0, 3'd3, 1'b1, 8'h55));
    // short chain: targets past the end produce nothing and change nothing
    write_chain(4'd3);
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd2, 3'd1, 3'd1, 1'b1, 8'h00));
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd3, 3'd1, 3'd2, 1'b1, 8'h00));
    send_item(make_item(lmcw_pkg::ACT_ROW,    3'd5, 3'd1, 3'd0, 1'b0, 8'hFF));
    send_item(make_item(lmcw_pkg::ACT_COLUMN, 3'd7, 3'd0, 3'd6, 1'b0, 8'hFF));
    send_item(make_item(lmcw_pkg::ACT_RAW,    3'd3, 3'd6, 3'd0, 1'b0, 8'h81));
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd2, 3'd1, 3'd4, 1'b1, 8'h00));
    // setting above the maximum acts as a full chain
    write_chain(4'd15);
    send_item(make_item(lmcw_pkg::ACT_RAW,    3'd7, 3'd2, 3'd0, 1'b0, 8'h81));
    send_item(make_item(lmcw_pkg::ACT_COLUMN, 3'd6, 3'd0, 3'd5, 1'b1, 8'h5A));
    // empty chain: every item is dropped
    write_chain(4'd0);
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd0, 3'd0, 3'd0, 1'b1, 8'h00));
    send_item(make_item(lmcw_pkg::ACT_RAW,    3'd0, 3'd7, 3'd0, 1'b0, 8'hFF));
    // single driver, no NOP padding
    write_chain(4'd1);
    send_item(make_item(lmcw_pkg::ACT_ROW,    3'd0, 3'd7, 3'd0, 1'b0, 8'h01));
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd1, 3'd7, 3'd7, 1'b1, 8'h00));
    send_item(make_item(lmcw_pkg::ACT_LED,    3'd0, 3'd7, 3'd7, 1'b1, 8'hFF));
  endtask

  task automatic test_random_chains();
    logic [3:0]         settings [10] = '{4'd8, 4'd1, 4'd5, 4'd15, 4'd3,
                                          4'd2, 4'd6, 4'd7, 4'd4, 4'd12};
    int unsigned        hits;
    lmcw_pkg::in_item_t it;
    for (int p = 0; p < 10; p++) begin
      write_chain(settings[p]);
      // vary pacing per phase, including stretches with no idling at all
      sender_gaps     = (p % 3 != 1) && (p % 4 != 3);
      receiver_stalls = (p % 3 != 1) && (p % 4 != 2);
      hits = 0;
      while (hits < PHASE_ITEMS) begin
        it = random_item();
        if (it.device < active_devices()) hits++;
        send_item(it);
      end
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_backpressure();
    lmcw_pkg::in_item_t it;
    write_chain(4'd8);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = HOLD_CYCLES;
    // keep offering mostly column writes while the output is held off
    for (int i = 0; i < 24; i++) begin
      it = random_item();
      if ($urandom_range(0, 3) != 0) it.action = lmcw_pkg::ACT_COLUMN;
      send_item(it);
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_drain_pause();
    write_chain(4'd4);
    for (int i = 0; i < 6; i++) send_item(random_item());
    wait_idle();
    for (int i = 0; i < 6; i++) send_item(random_item());
  endtask

  // Receiver: random stall runs, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!receiver_stalls) begin
      out_stall <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      stall_now = ($urandom_range(0, 2) == 0);
      run_left  = stall_now ? $urandom_range(0, 5) : $urandom_range(0, 11);
      out_stall <= stall_now;
    end
  end

  // Compare each transferred word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: serial_word actual %h", out_data.serial_word);
        errors++;
      end else begin
        oldest_word = expected_words.pop_front();
        words_checked++;
        if (out_data.serial_word !== oldest_word.serial_word) begin
          $error("serial_word expected %h actual %h",
                 oldest_word.serial_word, out_data.serial_word);
          errors++;
        end
        if (out_data.frame_end !== oldest_word.frame_end) begin
          $error("frame_end expected %b actual %b",
                 oldest_word.frame_end, out_data.frame_end);
          errors++;
        end
        if (out_data.item_end !== oldest_word.item_end) begin
          $error("item_end expected %b actual %b",
                 oldest_word.item_end, out_data.item_end);
          errors++;
        end
      end
    end
  end

  // End the run if nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d words still expected", expected_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_chains();
    test_backpressure();
    test_drain_pause();

    // drain and let the block settle
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items and %0d words over %0d chain settings (0 to 15),",
             items_sent, words_checked, chains_used);
    $display("with paced and stall-free phases and a long output hold-off.");
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ led_matrix_chain_writer.f @@
rtl/lmcw_pkg.sv
rtl/lmcw_ctrl.sv
rtl/lmcw_dpath.sv
rtl/led_matrix_chain_writer.sv
dv/testbench.sv
